/* rtl/assert_macros.svh */
// assertion macros shared by the highlighter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, clocked on i_clk, off during reset
`define MKLH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies a consequence in the next
`define MKLH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mklh_pkg.sv */
// shared types and constants of the multi keyword line highlighter
`default_nettype none
package mklh_pkg;

    localparam int CHAR_W           = 8;
    localparam int STYLE_W          = 4;
    localparam int KW_W             = 2;
    localparam int LEN_W            = 4;
    localparam int COUNT_W          = 3;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_INDEX_W      = 3;
    localparam int DEF_MAX_PATTERN  = 8;
    localparam int DEF_NUM_KEYWORDS = 4;

    localparam logic [STYLE_W-1:0] MAX_STYLE = 4'd11;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_ZERO = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTHS      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STYLES       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT        = 3'd6;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_out;
        logic               highlighted;
        logic [STYLE_W-1:0] style_index;
        logic [KW_W-1:0]    keyword_index;
        logic               match_begin;
        logic               match_finish;
        logic               line_last;
        logic               line_had_match;
    } t_result;

    typedef struct packed {
        logic accept;
        logic shift;
    } t_cell_ctrl;

endpackage
`default_nettype wire

/* rtl/mklh_cell.sv */
// one window cell: holds a character, compares it with the byte at its position in every keyword
`default_nettype none
module mklh_cell #(
    parameter int NUM_KEYWORDS = mklh_pkg::DEF_NUM_KEYWORDS
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  mklh_pkg::t_cell_ctrl                         i_ctrl,
    input  wire [mklh_pkg::CHAR_W-1:0]                   i_char_in,
    input  wire                                          i_prev_valid,
    input  wire [mklh_pkg::CHAR_W-1:0]                   i_next_char,
    input  wire                                          i_next_valid,
    input  wire [NUM_KEYWORDS-1:0][mklh_pkg::CHAR_W-1:0] i_pattern,
    output logic                                         o_valid,
    output logic [mklh_pkg::CHAR_W-1:0]                  o_view_char,
    output logic                                         o_view_valid,
    output logic [NUM_KEYWORDS-1:0]                      o_eq
);
    import mklh_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] n_char;
    logic              ins;

    // first empty cell takes the new character
    assign ins          = i_ctrl.accept && !r_valid && i_prev_valid;
    assign o_view_valid = r_valid || ins;
    assign o_view_char  = r_valid ? r_char : i_char_in;
    assign o_valid      = r_valid;

    always_comb begin
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            o_eq[k] = (o_view_char == i_pattern[k]);
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_char  = r_char;
        if (i_ctrl.shift) begin
            n_valid = i_next_valid;
            n_char  = i_next_char;
        end else if (ins) begin
            n_valid = 1'b1;
            n_char  = i_char_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

endmodule
`default_nettype wire

/* rtl/mklh_outbuf.sv */
// output register with skid stage for result transactions
`default_nettype none
module mklh_outbuf (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  mklh_pkg::t_result i_data,
    output logic              o_valid,
    input  wire               i_ready,
    output mklh_pkg::t_result o_data
);
    import mklh_pkg::*;

    logic    r_main_valid;
    logic    n_main_valid;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_main;
    t_result n_main;
    t_result r_skid;
    t_result n_skid;
    logic    pop;

    assign pop     = r_main_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (pop) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_valid && (!r_main_valid || pop)) begin
            n_main       = i_data;
            n_main_valid = 1'b1;
        end else if (i_valid) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end else if (pop) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule
`default_nettype wire

/* rtl/multi_keyword_line_highlighter_core.sv */
// top level: keyword window chain, match priority, line flush and output stage
// a character is emitted in the cycle in which MAX_PATTERN-1 later characters are taken,
//   or at line end; the result is then held in the output register before it leaves
// throughput: one character per cycle while the output stage is ready; a line end holds
//   off input while the characters left in the window drain, one per cycle
// reset clears the window, match state, line flush, output stage and config registers
`default_nettype none
`include "assert_macros.svh"
module multi_keyword_line_highlighter_core #(
    parameter int MAX_PATTERN  = mklh_pkg::DEF_MAX_PATTERN,
    parameter int NUM_KEYWORDS = mklh_pkg::DEF_NUM_KEYWORDS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [mklh_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire [mklh_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire [mklh_pkg::CHAR_W-1:0]         i_char_in,
    input  wire                                i_line_end,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [mklh_pkg::CHAR_W-1:0]        o_char_out,
    output logic                               o_highlighted,
    output logic [mklh_pkg::STYLE_W-1:0]       o_style_index,
    output logic [mklh_pkg::KW_W-1:0]          o_keyword_index,
    output logic                               o_match_begin,
    output logic                               o_match_finish,
    output logic                               o_line_last,
    output logic                               o_line_had_match
);
    import mklh_pkg::*;

    localparam int HLW = $clog2(MAX_PATTERN);

    // configuration
    logic [NUM_KEYWORDS-1:0][MAX_PATTERN-1:0][CHAR_W-1:0] r_pattern;
    logic [NUM_KEYWORDS-1:0][LEN_W-1:0]                   r_lengths;
    logic [NUM_KEYWORDS-1:0][STYLE_W-1:0]                 r_styles;
    logic [COUNT_W-1:0]                                   r_count;

    // match and line state
    logic               r_flush;
    logic               n_flush;
    logic [HLW-1:0]     r_hl_left;
    logic [HLW-1:0]     n_hl_left;
    logic [STYLE_W-1:0] r_style;
    logic [STYLE_W-1:0] n_style;
    logic [KW_W-1:0]    r_kw;
    logic [KW_W-1:0]    n_kw;
    logic               r_any;
    logic               n_any;

    // chain
    t_cell_ctrl                                           cell_ctrl;
    logic [MAX_PATTERN-1:0]                               cell_valid;
    logic [MAX_PATTERN-1:0]                               view_valid;
    logic [MAX_PATTERN-1:0][CHAR_W-1:0]                   view_char;
    logic [MAX_PATTERN-1:0][NUM_KEYWORDS-1:0]             eq;
    logic [MAX_PATTERN-1:0][NUM_KEYWORDS-1:0][CHAR_W-1:0] pat_col;
    logic [MAX_PATTERN-1:0]                               prev_valid;
    logic [MAX_PATTERN-1:0]                               next_valid;
    logic [MAX_PATTERN-1:0][CHAR_W-1:0]                   next_char;

    logic               accept;
    logic               buf_ready;
    logic               end_mode;
    logic               emit;
    logic               last;
    logic [NUM_KEYWORDS-1:0] hit;
    logic               hit_any;
    logic [KW_W-1:0]    win_idx;
    logic [LEN_W-1:0]   win_len;
    logic [STYLE_W-1:0] win_style_raw;
    logic [STYLE_W-1:0] win_style;
    t_result            res;
    t_result            out_res;

    assign o_in_ready = !r_flush && buf_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign end_mode   = r_flush || (accept && i_line_end);
    assign emit       = buf_ready &&
                        (r_flush || (accept && (i_line_end || view_valid[MAX_PATTERN-1])));
    assign last       = end_mode && !view_valid[1];

    assign cell_ctrl.accept = accept;
    assign cell_ctrl.shift  = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_lengths <= '0;
            r_styles  <= '0;
            r_count   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LENGTHS: r_lengths <= i_cfg_data[NUM_KEYWORDS*LEN_W-1:0];
                REG_STYLES:  r_styles  <= i_cfg_data[NUM_KEYWORDS*STYLE_W-1:0];
                REG_COUNT:   r_count   <= i_cfg_data[COUNT_W-1:0];
                default: begin
                    for (int k = 0; k < NUM_KEYWORDS; k++) begin
                        if (i_cfg_index == REG_PATTERN_ZERO + CFG_INDEX_W'(k)) begin
                            r_pattern[k] <= i_cfg_data[MAX_PATTERN*CHAR_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign prev_valid[i] = 1'b1;
        end else begin : g_body
            assign prev_valid[i] = cell_valid[i-1];
        end
        if (i == MAX_PATTERN - 1) begin : g_tail
            assign next_valid[i] = 1'b0;
            assign next_char[i]  = '0;
        end else begin : g_link
            assign next_valid[i] = view_valid[i+1];
            assign next_char[i]  = view_char[i+1];
        end
        for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_pat
            assign pat_col[i][k] = r_pattern[k][i];
        end

        mklh_cell #(
            .NUM_KEYWORDS(NUM_KEYWORDS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl),
            .i_char_in    (i_char_in),
            .i_prev_valid (prev_valid[i]),
            .i_next_char  (next_char[i]),
            .i_next_valid (next_valid[i]),
            .i_pattern    (pat_col[i]),
            .o_valid      (cell_valid[i]),
            .o_view_char  (view_char[i]),
            .o_view_valid (view_valid[i]),
            .o_eq         (eq[i])
        );
    end

    // keyword hits at the window head
    always_comb begin
        logic all_ok;
        all_ok = 1'b1;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            all_ok = 1'b1;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (LEN_W'(i) < r_lengths[k]) begin
                    all_ok = all_ok && view_valid[i] && eq[i][k];
                end
            end
            hit[k] = all_ok && (r_lengths[k] != '0) &&
                     (r_lengths[k] <= LEN_W'(MAX_PATTERN)) && (r_count > COUNT_W'(k));
        end
    end

    // lowest index wins
    always_comb begin
        win_idx       = '0;
        win_len       = '0;
        win_style_raw = '0;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            if (hit[k]) begin
                win_idx       = KW_W'(k);
                win_len       = r_lengths[k];
                win_style_raw = r_styles[k];
            end
        end
    end

    assign hit_any   = |hit;
    assign win_style = (win_style_raw > MAX_STYLE) ? MAX_STYLE : win_style_raw;

    always_comb begin
        res           = '0;
        res.char_out  = view_char[0];
        n_hl_left     = r_hl_left;
        n_style       = r_style;
        n_kw          = r_kw;
        n_any         = r_any;
        n_flush       = r_flush;
        if (emit) begin
            if (r_hl_left != '0) begin
                res.highlighted   = 1'b1;
                res.style_index   = r_style;
                res.keyword_index = r_kw;
                res.match_finish  = (r_hl_left == HLW'(1));
                n_hl_left         = r_hl_left - HLW'(1);
            end else if (hit_any) begin
                res.highlighted   = 1'b1;
                res.style_index   = win_style;
                res.keyword_index = win_idx;
                res.match_begin   = 1'b1;
                res.match_finish  = (win_len == LEN_W'(1));
                n_hl_left         = HLW'(win_len - LEN_W'(1));
                n_style           = win_style;
                n_kw              = win_idx;
                n_any             = 1'b1;
            end
            res.line_last      = last;
            res.line_had_match = last && n_any;
            if (end_mode) begin
                n_flush = view_valid[1];
            end
            if (last) begin
                n_hl_left = '0;
                n_style   = '0;
                n_kw      = '0;
                n_any     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush   <= 1'b0;
            r_hl_left <= '0;
            r_style   <= '0;
            r_kw      <= '0;
            r_any     <= 1'b0;
        end else begin
            r_flush   <= n_flush;
            r_hl_left <= n_hl_left;
            r_style   <= n_style;
            r_kw      <= n_kw;
            r_any     <= n_any;
        end
    end

    mklh_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (emit),
        .o_ready (buf_ready),
        .i_data  (res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_res)
    );

    assign o_char_out       = out_res.char_out;
    assign o_highlighted    = out_res.highlighted;
    assign o_style_index    = out_res.style_index;
    assign o_keyword_index  = out_res.keyword_index;
    assign o_match_begin    = out_res.match_begin;
    assign o_match_finish   = out_res.match_finish;
    assign o_line_last      = out_res.line_last;
    assign o_line_had_match = out_res.line_had_match;

    `MKLH_ASSERT(a_window_packed, ((cell_valid & (cell_valid + MAX_PATTERN'(1))) == '0), "window cells not packed at head")
    `MKLH_ASSERT(a_flush_head, (!r_flush || view_valid[0]), "flush with empty window")
    `MKLH_ASSERT(a_match_seen, ((r_hl_left == '0) || r_any), "match in progress without match flag")
    `MKLH_ASSERT_NEXT(a_line_clear, (emit && last), ((r_hl_left == '0) && !r_any && !r_flush && (cell_valid == '0)), "line state not cleared after line end")

endmodule
`default_nettype wire
